// ===== design/mean_intensity_histogram_macros.svh =====
// Assertion macros for the mean intensity histogram checker.
`ifndef MEAN_INTENSITY_HISTOGRAM_MACROS_SVH
`define MEAN_INTENSITY_HISTOGRAM_MACROS_SVH

// Same-cycle implication, quiet while reset is low.
`define MIH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mih: same-cycle check failed");

// Next-cycle implication, quiet while reset is low.
`define MIH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mih: next-cycle check failed");

`endif

// ===== design/mih_pkg.sv =====
// Shared types and constants of the mean intensity histogram.
package mih_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int BIN_BITS       = 8;
  localparam int NUM_BINS       = 256;
  localparam int BAR_BITS       = 8;
  localparam int CHAN_BITS      = 8;
  localparam int FIELD_BITS     = 24;
  localparam logic [BAR_BITS-1:0] BAR_HEIGHT_RST = 8'd100;

  // floor(x/3) == (x*683) >> 11 for every x up to 765
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef struct packed {
    logic                clear;
    logic                rd_en;
    logic [BIN_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [BIN_BITS-1:0] wr_addr;
  } store_req_t;

endpackage

// ===== design/mih_if.sv =====
// Handshake channels of the mean intensity histogram.
interface mih_in_if;
  import mih_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [CHAN_BITS-1:0] red;
  logic [CHAN_BITS-1:0] green;
  logic [CHAN_BITS-1:0] blue;
  logic [BIN_BITS-1:0]  bin_index;
  modport source (output valid, req_type, red, green, blue, bin_index, input ready);
  modport sink   (input valid, req_type, red, green, blue, bin_index, output ready);
endinterface

interface mih_out_if;
  import mih_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [BIN_BITS-1:0]   bin_number;
  logic [BAR_BITS-1:0]   bar_value;
  logic [FIELD_BITS-1:0] raw_count;
  logic [FIELD_BITS-1:0] peak_count;
  modport source (output valid, bin_number, bar_value, raw_count, peak_count, input ready);
  modport sink   (input valid, bin_number, bar_value, raw_count, peak_count, output ready);
endinterface

interface mih_cfg_if;
  import mih_pkg::*;
  logic                valid;
  logic                ready;
  logic [BAR_BITS-1:0] bar_height;
  modport source (output valid, bar_height, input ready);
  modport sink   (input valid, bar_height, output ready);
endinterface

// ===== design/mih_store.sv =====
// Bin count memory with per-bin valid flags; an unwritten bin reads as zero.
module mih_store
  import mih_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  store_req_t            req,
  input  logic [COUNT_BITS-1:0] wr_data,
  output logic [COUNT_BITS-1:0] rd_data
);

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]   valid_r;
  logic [COUNT_BITS-1:0] rd_q_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  // flags reset at once, so reset and clear need no sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.clear) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== design/mih_div.sv =====
// Restoring divider, one quotient bit per cycle; quotient known to fit BAR_BITS.
module mih_div
  import mih_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [COUNT_BITS+BAR_BITS-1:0] numer,
  input  logic [COUNT_BITS-1:0]          denom,
  output logic                           done,
  output logic [BAR_BITS-1:0]            quot
);

  localparam int CNT_BITS = $clog2(BAR_BITS);

  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] den_r;
  logic [BAR_BITS-1:0]   low_r;
  logic [BAR_BITS-1:0]   quot_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;

  // numerator high part is below denom, so the remainder stays in COUNT_BITS
  always_comb begin
    trial   = {rem_r, low_r[BAR_BITS-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= numer[COUNT_BITS+BAR_BITS-1:BAR_BITS];
      low_r <= numer[BAR_BITS-1:0];
      den_r <= denom;
      cnt_r <= CNT_BITS'(BAR_BITS - 1);
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      low_r  <= {low_r[BAR_BITS-2:0], 1'b0};
      quot_r <= {quot_r[BAR_BITS-2:0], ge};
      cnt_r  <= cnt_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== design/mean_intensity_histogram.sv =====
// Top level of the mean intensity histogram: sequencer, peak tracking, output stage.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------------
//  in_ch    | in  | valid/ready   | req_type, red, green, blue, bin_index
//  out_ch   | out | valid/ready   | bin_number, bar_value, raw_count, peak_count
//  cfg_ch   | in  | valid/ready   | bar_height (ready always high)
//
//  Add pixel: accept + memory read, then read-modify-write of the bin.
//  Read bin: memory read, then the bar_height*count multiply, then the 8-step
//  restoring divider, one quotient bit a cycle.
//  Clear: done at acceptance; bins carry valid flags, so neither reset nor clear sweeps memory.
//  in_ch.ready is high only while idle. A finished read waits in the output
//  register; a second read stalls in its last state until that register is free.
module mean_intensity_histogram
  import mih_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mih_in_if.sink    in_ch,
  mih_out_if.source out_ch,
  mih_cfg_if.sink   cfg_ch
);

  localparam int SUM_BITS  = CHAN_BITS + 2;
  localparam int MPR_BITS  = 2 * SUM_BITS;
  localparam int PROD_BITS = COUNT_BITS + BAR_BITS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  is_read_r;
  logic [BIN_BITS-1:0]   bin_r;
  logic [BAR_BITS-1:0]   bh_r;
  logic [COUNT_BITS-1:0] peak_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [PROD_BITS-1:0]  prod_r;
  logic [BAR_BITS-1:0]   quot_r;

  logic                  out_valid_r;
  logic [BIN_BITS-1:0]   obin_r;
  logic [BAR_BITS-1:0]   obar_r;
  logic [FIELD_BITS-1:0] oraw_r;
  logic [FIELD_BITS-1:0] opeak_r;

  logic                  in_acc;
  logic                  out_load;
  req_t                  req;
  logic [SUM_BITS-1:0]   sum;
  logic [MPR_BITS-1:0]   mean_prod;
  logic [BIN_BITS-1:0]   mean_bin;
  store_req_t            st_req;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] inc;
  logic                  div_done;
  logic [BAR_BITS-1:0]   div_quot;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign req          = req_t'(in_ch.req_type);

  // mean of the three channels by reciprocal multiply
  assign sum       = SUM_BITS'(in_ch.red) + SUM_BITS'(in_ch.green) + SUM_BITS'(in_ch.blue);
  assign mean_prod = MPR_BITS'(sum) * MPR_BITS'(RECIP3);
  assign mean_bin  = mean_prod[RECIP3_SHIFT+BIN_BITS-1:RECIP3_SHIFT];

  // saturating increment of the fetched bin
  assign inc = (rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1);

  always_comb begin
    st_req         = '0;
    st_req.rd_addr = (req == REQ_ADD) ? mean_bin : in_ch.bin_index;
    st_req.wr_addr = bin_r;
    if (in_acc) begin
      case (req)
        REQ_ADD:   st_req.rd_en = 1'b1;
        REQ_READ:  st_req.rd_en = 1'b1;
        REQ_CLEAR: st_req.clear = 1'b1;
        default:   st_req.rd_en = 1'b0;
      endcase
    end
    st_req.wr_en = (state_r == ST_FETCH) && !is_read_r;
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (req == REQ_ADD || req == REQ_READ)) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = is_read_r ? ST_MUL : ST_IDLE;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bh_r        <= BAR_HEIGHT_RST;
      peak_r      <= COUNT_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        bh_r <= cfg_ch.bar_height;
      end
      // peak never drops below one
      if (in_acc && req == REQ_CLEAR) begin
        peak_r <= COUNT_BITS'(1);
      end else if (st_req.wr_en && inc > peak_r) begin
        peak_r <= inc;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_read_r <= (req == REQ_READ);
      bin_r     <= st_req.rd_addr;
    end
    if (state_r == ST_FETCH) begin
      cnt_r  <= rd_data;
      prod_r <= PROD_BITS'(bh_r) * PROD_BITS'(rd_data);
    end
    if (div_done) begin
      quot_r <= div_quot;
    end
    if (out_load) begin
      obin_r  <= bin_r;
      obar_r  <= quot_r;
      oraw_r  <= FIELD_BITS'(cnt_r);
      opeak_r <= FIELD_BITS'(peak_r);
    end
  end

  mih_store #(.COUNT_BITS(COUNT_BITS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (st_req),
    .wr_data (inc),
    .rd_data (rd_data)
  );

  mih_div #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_MUL),
    .numer (prod_r),
    .denom (peak_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.bin_number = obin_r;
  assign out_ch.bar_value  = obar_r;
  assign out_ch.raw_count  = oraw_r;
  assign out_ch.peak_count = opeak_r;

endmodule

// ===== design/mih_chk.sv =====
// Port-level checker for the mean intensity histogram, bound to the top level.
`include "mean_intensity_histogram_macros.svh"

module mih_chk
  import mih_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [1:0]            in_req_type,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [FIELD_BITS-1:0] out_raw_count,
  input logic [FIELD_BITS-1:0] out_peak_count
);

  // a pending result is not withdrawn
  `MIH_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // add and read keep the block busy for at least the next cycle
  `MIH_ASSERT_NXT(a_busy_after_op, clk, rst_n,
                  in_valid && in_ready &&
                  (in_req_type == REQ_ADD || in_req_type == REQ_READ), !in_ready)

  // no bin exceeds the peak, and the peak is never zero, unless fields are masked
  `MIH_ASSERT_IMP(a_peak_bound, clk, rst_n, out_valid && (COUNT_BITS <= FIELD_BITS),
                  (out_raw_count <= out_peak_count) && (out_peak_count != '0))

endmodule

bind mean_intensity_histogram mih_chk #(.COUNT_BITS(COUNT_BITS)) u_mih_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_req_type    (in_ch.req_type),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_raw_count  (out_ch.raw_count),
  .out_peak_count (out_ch.peak_count)
);
